// ----- rtl/dnle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dnle_pkg;

	// field widths fixed by the buffer and byte formats
	localparam int ADDR_W = 11;
	localparam int BYTE_W = 8;
	localparam int SUM_W  = ADDR_W + 2;

	// defaults for the top level parameters and registers
	localparam int MAX_LABEL_DEF = 63;
	localparam logic [ADDR_W-1:0] OUT_LIMIT_RST = 11'd256;

	// special characters
	localparam logic [BYTE_W-1:0] DOT_CHAR = 8'd46;
	localparam logic [BYTE_W-1:0] NUL_CHAR = 8'd0;

	// request kinds
	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;
	localparam logic [1:0] ST_ROOM  = 2'd3;

	typedef struct packed {
		logic              req_type;
		logic [BYTE_W-1:0] char_byte;
	} in_item_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] write_addr;
		logic [BYTE_W-1:0] write_byte;
		logic              run_last;
		logic              name_done;
		logic [1:0]        status;
		logic [ADDR_W-1:0] total_len;
	} out_item_t;

	// results of one item, handed from the encoder to the output buffer
	typedef struct packed {
		out_item_t res0;
		out_item_t res1;
		logic      two;
	} enc_res_t;

endpackage

`default_nettype wire

// ----- rtl/dnle_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dnle_in_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire dnle_pkg::in_item_t req_item,
	input  wire logic               advance,
	output logic                    item_valid,
	output dnle_pkg::in_item_t      item
);
	import dnle_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	// room when empty or when the held item moves on this cycle
	assign req_ready  = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// input register, control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// input register, payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dnle_encode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dnle_encode #(
	parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [dnle_pkg::ADDR_W-1:0] cfg_wdata,
	input  wire logic                       fire,
	input  wire dnle_pkg::in_item_t         item,
	output dnle_pkg::enc_res_t              res
);
	import dnle_pkg::*;

	localparam int CNT_W = $clog2(MAX_LABEL + 2);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LABEL);

	logic [ADDR_W-1:0] out_limit_q;
	logic [ADDR_W-1:0] label_start_q, nxt_start;
	logic [CNT_W-1:0]  label_count_q, nxt_count, inc_count;
	logic [1:0]        error_code_q, nxt_err, end_err;
	logic              is_end;
	logic [SUM_W-1:0]  start_w, lim_w, len_w, inc_w, sum1, sum2, char_addr;

	// widened operands so no sum wraps
	assign start_w   = SUM_W'(label_start_q);
	assign lim_w     = SUM_W'(out_limit_q);
	assign len_w     = SUM_W'(label_count_q);
	assign inc_count = (label_count_q <= MAX_CNT) ? label_count_q + 1'b1 : label_count_q;
	assign inc_w     = SUM_W'(inc_count);
	assign sum1      = start_w + len_w + 1'b1;
	assign sum2      = start_w + len_w + 2'd2;
	assign char_addr = start_w + inc_w;
	assign is_end    = (item.req_type == REQ_END) || (item.char_byte == NUL_CHAR);

	// results and next state for the item in the input register
	always_comb begin
		nxt_start         = label_start_q;
		nxt_count         = label_count_q;
		nxt_err           = error_code_q;
		end_err           = error_code_q;
		res               = '0;
		res.res0.run_last = 1'b1;
		if (is_end) begin
			if (error_code_q == ST_OK) begin
				if (label_count_q > MAX_CNT) begin
					end_err = ST_LONG;
				end else if (sum2 >= lim_w) begin
					end_err = ST_ROOM;
				end
			end
			if (end_err != ST_OK) begin
				res.res0.name_done = 1'b1;
				res.res0.status    = end_err;
			end else begin
				res.res0.write_enable = 1'b1;
				res.res0.write_addr   = label_start_q;
				res.res0.write_byte   = BYTE_W'(label_count_q);
				res.res0.run_last     = 1'b0;
				res.res1.write_enable = 1'b1;
				res.res1.write_addr   = sum1[ADDR_W-1:0];
				res.res1.write_byte   = NUL_CHAR;
				res.res1.run_last     = 1'b1;
				res.res1.name_done    = 1'b1;
				res.res1.total_len    = sum2[ADDR_W-1:0];
				res.two               = 1'b1;
			end
			nxt_start = '0;
			nxt_count = '0;
			nxt_err   = ST_OK;
		end else if (error_code_q != ST_OK) begin
			res.res0.status = error_code_q;
		end else if (item.char_byte == DOT_CHAR) begin
			if (label_count_q == '0) begin
				nxt_err = ST_EMPTY;
			end else if (label_count_q > MAX_CNT) begin
				nxt_err = ST_LONG;
			end else if (sum1 >= lim_w) begin
				nxt_err = ST_ROOM;
			end
			if (nxt_err != ST_OK) begin
				res.res0.status = nxt_err;
			end else begin
				res.res0.write_enable = 1'b1;
				res.res0.write_addr   = label_start_q;
				res.res0.write_byte   = BYTE_W'(label_count_q);
				nxt_start             = sum1[ADDR_W-1:0];
				nxt_count             = '0;
			end
		end else begin
			nxt_count = inc_count;
			if (inc_count > MAX_CNT) begin
				nxt_err = ST_LONG;
			end else if (char_addr + 1'b1 >= lim_w) begin
				nxt_err = ST_ROOM;
			end
			if (nxt_err != ST_OK) begin
				res.res0.status = nxt_err;
			end else begin
				res.res0.write_enable = 1'b1;
				res.res0.write_addr   = char_addr[ADDR_W-1:0];
				res.res0.write_byte   = item.char_byte;
			end
		end
	end

	// buffer size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= OUT_LIMIT_RST;
		end else if (cfg_we) begin
			out_limit_q <= cfg_wdata;
		end
	end

	// label tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_start_q <= '0;
			label_count_q <= '0;
			error_code_q  <= ST_OK;
		end else if (fire) begin
			label_start_q <= nxt_start;
			label_count_q <= nxt_count;
			error_code_q  <= nxt_err;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dnle_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dnle_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire dnle_pkg::enc_res_t res,
	output logic                    can_load,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output dnle_pkg::out_item_t     rsp_item
);
	import dnle_pkg::*;

	logic      valid_s2;
	logic      sel_q;
	logic      showing_last;
	out_item_t res0_s2, res1_s2;
	logic      two_s2;

	assign showing_last = !two_s2 || sel_q;
	assign rsp_valid    = valid_s2;
	assign rsp_item     = sel_q ? res1_s2 : res0_s2;
	// free when empty or when the last result leaves this cycle
	assign can_load     = !valid_s2 || (rsp_ready && showing_last);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sel_q    <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			sel_q    <= 1'b0;
		end else if (valid_s2 && rsp_ready) begin
			if (showing_last) begin
				valid_s2 <= 1'b0;
				sel_q    <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load) begin
			res0_s2 <= res.res0;
			res1_s2 <= res.res1;
			two_s2  <= res.two;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dns_name_label_encoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake              payload
// req       in   req_valid/req_ready    req_item  (req_type, char_byte)
// rsp       out  rsp_valid/rsp_ready    rsp_item  (write, status, total fields)
// cfg       in   cfg_we                 cfg_wdata (out_limit)
//
// an item waits in the input register and is encoded as it moves
// into the result register; a character or dot gives one result, an end gives
// one or two, so the result register sets the rate: one result per cycle while rsp_ready is high.
// reset clears the label state and sets out_limit to 256; no clearing pass.
// a stalled rsp holds its result while the input register takes one more item.

module dns_name_label_encoder_unit #(
	parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire dnle_pkg::in_item_t          req_item,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output dnle_pkg::out_item_t              rsp_item,
	input  wire logic                        cfg_we,
	input  wire logic [dnle_pkg::ADDR_W-1:0] cfg_wdata
);
	import dnle_pkg::*;

	logic     item_valid;
	in_item_t item;
	logic     can_load;
	logic     advance;
	enc_res_t res;

	// move the held item into the result register
	assign advance = item_valid && can_load;

	dnle_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_item   (req_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	dnle_encode #(
		.MAX_LABEL (MAX_LABEL)
	) u_encode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (advance),
		.item      (item),
		.res       (res)
	);

	dnle_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.can_load  (can_load),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

endmodule

`default_nettype wire

// ----- tb/dns_name_label_encoder_checker.sv -----
`timescale 1ns / 1ps

// watches the request, result and config ports, predicts the buffer writes
// of every request transfer and compares them against the result transfers
module dns_name_label_encoder_checker
	import dnle_pkg::*;
#(
	parameter int MAX_LABEL = MAX_LABEL_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  in_item_t          req_item,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  out_item_t         rsp_item,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	output int                mismatches,
	output int                outstanding
);

	// predicted buffer writes, oldest first
	out_item_t exp_writes[$];
	out_item_t head_write;

	// encoder state as seen from outside
	int         limit_q;
	int         lbl_start;
	int         lbl_count;
	logic [1:0] name_err;
	int         err_cnt;

	function automatic void queue_write(logic we, int addr, int data, logic last,
			logic done, logic [1:0] st, int total);
		out_item_t r;
		r.write_enable = we;
		r.write_addr   = addr[ADDR_W-1:0];
		r.write_byte   = data[BYTE_W-1:0];
		r.run_last     = last;
		r.name_done    = done;
		r.status       = st;
		r.total_len    = total[ADDR_W-1:0];
		exp_writes.push_back(r);
	endfunction

	function automatic void clear_name();
		lbl_start = 0;
		lbl_count = 0;
		name_err  = ST_OK;
	endfunction

	// writes caused by one request transfer
	function automatic void encode_item(in_item_t it);
		int len;
		int place;
		len = lbl_count;
		if (it.req_type == REQ_END || it.char_byte == NUL_CHAR) begin
			// end of name: last length plus terminator, or the latched error
			if (name_err == ST_OK) begin
				if (len > MAX_LABEL)
					name_err = ST_LONG;
				else if (lbl_start + len + 2 >= limit_q)
					name_err = ST_ROOM;
			end
			if (name_err != ST_OK) begin
				queue_write(1'b0, 0, 0, 1'b1, 1'b1, name_err, 0);
			end else begin
				queue_write(1'b1, lbl_start, len, 1'b0, 1'b0, ST_OK, 0);
				queue_write(1'b1, lbl_start + len + 1, 0, 1'b1, 1'b1, ST_OK,
					lbl_start + len + 2);
			end
			clear_name();
		end else if (name_err != ST_OK) begin
			queue_write(1'b0, 0, 0, 1'b1, 1'b0, name_err, 0);
		end else if (it.char_byte == DOT_CHAR) begin
			// dot closes the open label and opens the next length slot
			if (len == 0)
				name_err = ST_EMPTY;
			else if (len > MAX_LABEL)
				name_err = ST_LONG;
			else if (lbl_start + len + 1 >= limit_q)
				name_err = ST_ROOM;
			if (name_err != ST_OK) begin
				queue_write(1'b0, 0, 0, 1'b1, 1'b0, name_err, 0);
			end else begin
				queue_write(1'b1, lbl_start, len, 1'b1, 1'b0, ST_OK, 0);
				lbl_start = (lbl_start + len + 1) & 'h7FF;
				lbl_count = 0;
			end
		end else begin
			// ordinary character goes behind the length slot and the label's earlier characters
			if (lbl_count <= MAX_LABEL)
				lbl_count++;
			place = lbl_start + lbl_count;
			if (lbl_count > MAX_LABEL)
				name_err = ST_LONG;
			else if (place + 1 >= limit_q)
				name_err = ST_ROOM;
			if (name_err != ST_OK)
				queue_write(1'b0, 0, 0, 1'b1, 1'b0, name_err, 0);
			else
				queue_write(1'b1, place, it.char_byte, 1'b1, 1'b0, ST_OK, 0);
		end
	endfunction

	function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", fname, want, got);
			err_cnt++;
		end
	endfunction

	// sample every port at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_writes.delete();
			limit_q = OUT_LIMIT_RST;
			clear_name();
			err_cnt = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (req_valid && req_ready)
				encode_item(req_item);
			if (rsp_valid && rsp_ready) begin
				if (exp_writes.size() == 0) begin
					$error("result transfer with nothing expected: addr %0d byte %0d",
						rsp_item.write_addr, rsp_item.write_byte);
					err_cnt++;
				end else begin
					head_write = exp_writes.pop_front();
					check_field("write_enable", head_write.write_enable, rsp_item.write_enable);
					check_field("write_addr", head_write.write_addr, rsp_item.write_addr);
					check_field("write_byte", head_write.write_byte, rsp_item.write_byte);
					check_field("run_last", head_write.run_last, rsp_item.run_last);
					check_field("name_done", head_write.name_done, rsp_item.name_done);
					check_field("status", head_write.status, rsp_item.status);
					check_field("total_len", head_write.total_len, rsp_item.total_len);
				end
			end
			// new limit applies from the next transfer on
			if (cfg_we)
				limit_q = cfg_wdata;
			mismatches <= err_cnt;
			outstanding <= exp_writes.size();
		end
	end

endmodule

// ----- tb/dns_name_label_encoder_unit_tb.sv -----
`timescale 1ns / 1ps

module dns_name_label_encoder_unit_tb;
	import dnle_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int NAME_ITEMS = 800;
	localparam int PHASES     = 6;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	in_item_t          req_item  = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	out_item_t         rsp_item;
	logic              cfg_we    = 1'b0;
	logic [ADDR_W-1:0] cfg_wdata = '0;
	int                mismatches;
	int                outstanding;

	// stimulus and stall controls
	int   items_sent = 0;
	int   burst_left = 0;
	bit   tx_gaps    = 1'b0;
	logic rx_steady  = 1'b1;
	int   rx_hold    = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	dns_name_label_encoder_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item (req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item (rsp_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	dns_name_label_encoder_checker enc_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_item   (req_item),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_item   (rsp_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// receiver: always ready when steady, else alternating ready and stall runs of random length
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
		end else if (rx_steady) begin
			rsp_ready <= 1'b1;
		end else if (rsp_ready) begin
			rsp_ready <= 1'b0;
			rx_hold = $urandom_range(0, 5);
		end else begin
			rsp_ready <= 1'b1;
			rx_hold = $urandom_range(0, 15);
		end
	end

	// one request transfer, sent in bursts with random gaps when tx_gaps is set
	task automatic send_item(logic kind, logic [BYTE_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = tx_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req_item <= '{req_type: kind, char_byte: ch};
		do @(posedge clk); while (!req_ready);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_char(logic [BYTE_W-1:0] ch);
		send_item(REQ_CHAR, ch);
	endtask

	// any byte but the dot and the nul
	function automatic logic [BYTE_W-1:0] label_char();
		logic [BYTE_W-1:0] c;
		do c = BYTE_W'($urandom_range(1, 255)); while (c == DOT_CHAR);
		return c;
	endfunction

	task automatic send_label(int n);
		repeat (n) send_char(label_char());
	endtask

	// mostly well-formed names with random content, some noise and broken ones
	task automatic send_name();
		int labels;
		int pick;
		labels = $urandom_range(0, 4);
		if ($urandom_range(0, 19) == 0) begin
			// raw bytes, stray dots and early ends included
			repeat ($urandom_range(1, 16)) send_char(BYTE_W'($urandom_range(0, 255)));
		end else begin
			for (int i = 0; i < labels; i++) begin
				if (i > 0)
					send_char(DOT_CHAR);
				pick = $urandom_range(0, 99);
				if (pick < 4)
					send_label(0);
				else if (pick < 10)
					send_label(MAX_LABEL_DEF);
				else if (pick < 14)
					send_label($urandom_range(MAX_LABEL_DEF + 1, MAX_LABEL_DEF + 3));
				else
					send_label($urandom_range(1, 12));
			end
			if (labels > 0 && $urandom_range(0, 9) == 0)
				send_char(DOT_CHAR);
		end
		// end by request kind or by a nul character
		if ($urandom_range(0, 1))
			send_item(REQ_END, BYTE_W'($urandom_range(0, 255)));
		else
			send_char(NUL_CHAR);
	endtask

	// hold the sender until every predicted write has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_limit(int v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[ADDR_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin
		int phase_limit;
		int base_items;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty name, then a single label closed by nul
		send_item(REQ_END, 8'hFF);
		send_char(8'hFF);
		send_char(NUL_CHAR);
		// trailing dot gives an extra zero length
		send_char(8'h01);
		send_char(DOT_CHAR);
		send_char(8'h80);
		send_char(DOT_CHAR);
		send_item(REQ_END, 8'h00);
		// leading dot
		send_char(DOT_CHAR);
		send_item(REQ_END, DOT_CHAR);
		// empty inner label, later characters only see the latched error
		send_char(8'h7F);
		send_char(DOT_CHAR);
		send_char(DOT_CHAR);
		send_char(8'h41);
		send_item(REQ_END, 8'h55);
		// smallest buffer: no room for anything
		write_limit(1);
		send_char(8'h61);
		send_item(REQ_END, 8'h00);
		send_item(REQ_END, 8'h00);
		// room runs out at the end item
		write_limit(5);
		send_char(8'h61);
		send_char(8'h62);
		send_char(8'h63);
		send_item(REQ_END, 8'h00);

		// random names over several buffer sizes
		base_items = items_sent;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_limit = 2047;
				1: phase_limit = 1;
				2: phase_limit = $urandom_range(2, 40);
				3: phase_limit = OUT_LIMIT_RST;
				4: phase_limit = $urandom_range(41, 300);
				default: phase_limit = 2047;
			endcase
			write_limit(phase_limit);
			tx_gaps = (ph != 0);
			rx_steady <= (ph == 0 || ph == 3);
			while (items_sent - base_items < (ph + 1) * NAME_ITEMS / PHASES)
				send_name();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog: too long without any transfer
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/dnle_pkg.sv
rtl/dnle_in_reg.sv
rtl/dnle_encode.sv
rtl/dnle_out_buf.sv
rtl/dns_name_label_encoder_unit.sv
tb/dns_name_label_encoder_checker.sv
tb/dns_name_label_encoder_unit_tb.sv
